[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ast_pkg.sv]
// types and constants for the assembly source tokenizer
`timescale 1ns / 1ps

package ast_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SKIP,
    MODE_MINUS,
    MODE_INT,
    MODE_IDENT
  } mode_t;

  localparam logic [2:0] KIND_INT     = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_REG     = 3'd2;
  localparam logic [2:0] KIND_ILLEGAL = 3'd3;
  localparam logic [2:0] KIND_EOF     = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [63:0] MAG_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG = 64'h8000_0000_0000_0000;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [15:0] length;
    logic [31:0] line;
    logic [31:0] column;
    logic        range_error;
    logic        last;
  } result_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[src/ast_scan.sv]
// scanner state and per-byte token logic
`timescale 1ns / 1ps

module ast_scan import ast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  output push_t      push
);

  mode_t       mode, mode_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic        ovf, ovf_next;
  logic        regdig, regdig_next;
  logic        regtok, regtok_next;
  logic [15:0] len, len_next;
  logic [31:0] cur_line, cur_line_next;
  logic [31:0] cur_col, cur_col_next;
  logic [31:0] tok_line, tok_line_next;
  logic [31:0] tok_col, tok_col_next;

  logic        is_dig, is_alpha, is_space;
  logic [3:0]  digit;
  logic [63:0] lim;
  logic [67:0] prod;
  logic        mac_ovf;
  logic [63:0] mac_val;

  logic        pend_valid, tail_valid, do_skip, do_idle, eof;
  result_t     pend, tail;

  function automatic result_t mk(input logic [2:0] kind, input logic [63:0] value,
                                 input logic [15:0] length, input logic [31:0] line,
                                 input logic [31:0] column, input logic rng);
    result_t r;
    r.kind        = kind;
    r.value       = value;
    r.length      = length;
    r.line        = line;
    r.column      = column;
    r.range_error = rng;
    r.last        = 1'b1;
    return r;
  endfunction

  assign is_dig   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign is_alpha = ((char_byte >= 8'h41) && (char_byte <= 8'h5A)) ||
                    ((char_byte >= 8'h61) && (char_byte <= 8'h7A));
  assign is_space = (char_byte == CH_SPACE) || ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
  assign digit    = char_byte[3:0];

  // acc*10 + d against the limit, in a wide enough word to never wrap
  assign lim     = neg ? MAG_NEG : MAG_POS;
  assign prod    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, digit};
  assign mac_ovf = prod > {4'd0, lim};
  assign mac_val = mac_ovf ? lim : prod[63:0];

  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    neg_next      = neg;
    ovf_next      = ovf;
    regdig_next   = regdig;
    regtok_next   = regtok;
    len_next      = len;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    pend_valid    = 1'b0;
    tail_valid    = 1'b0;
    pend          = mk(KIND_EOF, 64'd0, 16'd0, cur_line, cur_col, 1'b0);
    tail          = mk(KIND_EOF, 64'd0, 16'd0, cur_line, cur_col, 1'b0);
    do_skip       = 1'b0;
    do_idle       = 1'b0;
    eof           = 1'b0;

    unique case (mode)
      MODE_SKIP: do_skip = 1'b1;
      MODE_MINUS: begin
        if (is_dig) begin
          mode_next = MODE_INT;
          neg_next  = 1'b1;
          acc_next  = {60'd0, digit};
          len_next  = 16'd2;
        end else begin
          // lone minus is an illegal character
          pend_valid = 1'b1;
          pend       = mk(KIND_ILLEGAL, 64'd0, 16'd1, tok_line, tok_col, 1'b0);
          do_skip    = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_dig) begin
          if (!ovf) begin
            acc_next = mac_val;
            ovf_next = mac_ovf;
          end
          if (len != LEN_MAX) len_next = len + 16'd1;
        end else begin
          pend_valid = 1'b1;
          pend       = mk(KIND_INT, neg ? (64'd0 - acc) : acc, len, tok_line, tok_col, ovf);
          mode_next  = MODE_IDLE;
          if (ovf) do_skip = 1'b1;
          else     do_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_alpha || is_dig || (char_byte == CH_UNDER)) begin
          if (len != LEN_MAX) len_next = len + 16'd1;
          if (regdig) begin
            if (is_dig) acc_next = mac_val;
            else        regdig_next = 1'b0;
          end
        end else begin
          pend_valid = 1'b1;
          if (regtok) pend = mk(KIND_REG, acc, len, tok_line, tok_col, 1'b0);
          else        pend = mk(KIND_IDENT, 64'd0, len, tok_line, tok_col, 1'b0);
          do_idle = 1'b1;
        end
      end
      MODE_IDLE: do_idle = 1'b1;
      default:   do_idle = 1'b1;
    endcase

    // discard to end of line
    if (do_skip) begin
      if (char_byte == CH_NUL) eof = 1'b1;
      else mode_next = (char_byte == CH_LF) ? MODE_IDLE : MODE_SKIP;
    end

    // between tokens
    if (do_idle) begin
      mode_next = MODE_IDLE;
      if (char_byte == CH_NUL) begin
        eof = 1'b1;
      end else if (is_space || (char_byte == CH_COMMA)) begin
        mode_next = MODE_IDLE;
      end else if (char_byte == CH_SEMI) begin
        mode_next = MODE_SKIP;
      end else if (is_dig || (char_byte == CH_MINUS) || is_alpha) begin
        tok_line_next = cur_line;
        tok_col_next  = cur_col;
        acc_next      = 64'd0;
        neg_next      = 1'b0;
        ovf_next      = 1'b0;
        regdig_next   = 1'b0;
        regtok_next   = 1'b0;
        len_next      = 16'd1;
        if (is_dig) begin
          mode_next = MODE_INT;
          acc_next  = {60'd0, digit};
        end else if (char_byte == CH_MINUS) begin
          mode_next = MODE_MINUS;
        end else begin
          mode_next   = MODE_IDENT;
          regtok_next = (char_byte == CH_R);
          regdig_next = (char_byte == CH_R);
        end
      end else begin
        tail_valid = 1'b1;
        tail       = mk(KIND_ILLEGAL, 64'd0, 16'd1, cur_line, cur_col, 1'b0);
        mode_next  = MODE_SKIP;
      end
    end

    if (eof) tail_valid = 1'b1;

    if (char_byte == CH_LF) begin
      if (cur_line != POS_MAX) cur_line_next = cur_line + 32'd1;
      cur_col_next = 32'd1;
    end else if (char_byte != CH_NUL) begin
      if (cur_col != POS_MAX) cur_col_next = cur_col + 32'd1;
    end

    // end of text starts a fresh text
    if (eof) begin
      mode_next     = MODE_IDLE;
      acc_next      = 64'd0;
      neg_next      = 1'b0;
      ovf_next      = 1'b0;
      regdig_next   = 1'b0;
      regtok_next   = 1'b0;
      len_next      = 16'd0;
      cur_line_next = 32'd1;
      cur_col_next  = 32'd1;
      tok_line_next = 32'd1;
      tok_col_next  = 32'd1;
    end
  end

  always_comb begin
    push.count       = accept ? ({1'b0, pend_valid} + {1'b0, tail_valid}) : 2'd0;
    push.first       = pend_valid ? pend : tail;
    push.first.last  = !(pend_valid && tail_valid);
    push.second      = tail;
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      acc      <= 64'd0;
      neg      <= 1'b0;
      ovf      <= 1'b0;
      regdig   <= 1'b0;
      regtok   <= 1'b0;
      len      <= 16'd0;
      cur_line <= 32'd1;
      cur_col  <= 32'd1;
      tok_line <= 32'd1;
      tok_col  <= 32'd1;
    end else if (accept) begin
      mode     <= mode_next;
      acc      <= acc_next;
      neg      <= neg_next;
      ovf      <= ovf_next;
      regdig   <= regdig_next;
      regtok   <= regtok_next;
      len      <= len_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
    end
  end

endmodule

[src/ast_queue.sv]
// result queue taking up to two tokens per cycle and giving one
`timescale 1ns / 1ps

module ast_queue import ast_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output logic    valid,
  output logic    full,
  output result_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign wr_ptr1 = wrap_inc(wr_ptr);
  assign valid   = (count != '0);
  // room for two results must remain before a byte is taken
  assign full    = (count > CW'(DEPTH - 2));
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots[wr_ptr] <= push.first;
    if (push.count == 2'd2) slots[wr_ptr1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.count == 2'd1)      wr_ptr <= wr_ptr1;
      else if (push.count == 2'd2) wr_ptr <= wrap_inc(wr_ptr1);
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule

[src/assembly_source_tokenizer.sv]
// Assembly source tokenizer: takes one source byte per cycle (byte 0 ends the text)
// and returns integer, identifier, register, illegal-character and end-of-text
// tokens with length and starting line/column. Each byte is scanned in the cycle it
// is accepted; the one or two tokens it ends go into a small result queue that
// drains one token per cycle. Input runs at one byte per cycle as long as the queue
// has room for two tokens. Two-token bytes never come back to back, so with a
// free-running output the queue holds at most two tokens and char_stall stays low;
// it rises only when output back-pressure fills the queue. With an empty queue the
// first token of a byte appears in the cycle after the byte is accepted; a second token
// follows once the first has been popped.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module assembly_source_tokenizer import ast_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_byte,
  output logic               token_valid,
  input  logic               token_stall,
  output logic [2:0]         token_kind,
  output logic signed [63:0] token_value,
  output logic [15:0]        token_length,
  output logic [31:0]        start_line,
  output logic [31:0]        start_column,
  output logic               range_error,
  output logic               last_result
);

  logic    accept, pop;
  push_t   push;
  result_t head;

  assign accept = char_valid && !char_stall;
  assign pop    = token_valid && !token_stall;

  ast_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_byte (char_byte),
    .push      (push)
  );

  ast_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .valid (token_valid),
    .full  (char_stall),
    .head  (head)
  );

  assign token_kind   = head.kind;
  assign token_value  = $signed(head.value);
  assign token_length = head.length;
  assign start_line   = head.line;
  assign start_column = head.column;
  assign range_error  = head.range_error;
  assign last_result  = head.last;

  `ASSERT_CLK(a_eof_is_last, token_valid && (token_kind == KIND_EOF) |-> last_result,
              "end of text token not marked last")
  `ASSERT_CLK(a_range_only_int, token_valid && range_error |-> (token_kind == KIND_INT),
              "range flag on a non-integer token")
  `ASSERT_CLK(a_value_zero, token_valid && (token_kind != KIND_INT) &&
              (token_kind != KIND_REG) |-> (token_value == 64'sd0),
              "nonzero value on a token without a value")
  `ASSERT_ALWAYS(a_no_accept_in_reset, rst |=> !token_valid,
                 "token queue not empty after reset")

endmodule
